@@ rtl/core/spk_pkg.sv @@
package spk_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned IDX_W     = 5;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        KEY_IDX_ZERO  = 2'd0,
        KEY_IDX_ONE   = 2'd1,
        KEY_IDX_TWO   = 2'd2,
        KEY_IDX_THREE = 2'd3
    } t_key_idx;

    // controller -> datapath
    typedef struct packed {
        logic             load;
        logic             step;
        logic             emit;
        logic [IDX_W-1:0] round_idx;
    } t_dp_cmd;

    function automatic t_word rol3(input t_word v);
        return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
    endfunction

    function automatic t_word ror8(input t_word v);
        return {v[7:0], v[WORD_W-1:8]};
    endfunction

endpackage

@@ rtl/core/spk_datapath.sv @@
module spk_datapath
    import spk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_word                i_cfg_data,
    input  t_word                i_plain_x,
    input  t_word                i_plain_y,
    output t_word                o_cipher_x,
    output t_word                o_cipher_y
);

    t_word r_key0, r_key1, r_key2, r_key3;
    t_word r_x, r_y, r_s, r_l0, r_l1, r_l2;
    t_word r_out_x, r_out_y;
    t_word n_x, n_y, n_s, n_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg_we) begin
            unique case (t_key_idx'(i_cfg_index))
                KEY_IDX_ZERO:  r_key0 <= i_cfg_data;
                KEY_IDX_ONE:   r_key1 <= i_cfg_data;
                KEY_IDX_TWO:   r_key2 <= i_cfg_data;
                KEY_IDX_THREE: r_key3 <= i_cfg_data;
                default:       r_key0 <= r_key0;
            endcase
        end
    end

    // round and key schedule step side by side
    always_comb begin
        n_x = (ror8(r_x) + r_y) ^ r_s;
        n_y = rol3(r_y) ^ n_x;
        n_l = (r_s + ror8(r_l0)) ^ {{(WORD_W-IDX_W){1'b0}}, i_cmd.round_idx};
        n_s = rol3(r_s) ^ n_l;
    end

    // l words shift through a three-deep line; head is always r_l0
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_plain_x;
            r_y  <= i_plain_y;
            r_s  <= r_key0;
            r_l0 <= r_key1;
            r_l1 <= r_key2;
            r_l2 <= r_key3;
        end else if (i_cmd.step) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_s  <= n_s;
            r_l0 <= r_l1;
            r_l1 <= r_l2;
            r_l2 <= n_l;
        end
        if (i_cmd.emit) begin
            r_out_x <= r_x;
            r_out_y <= r_y;
        end
    end

    assign o_cipher_x = r_out_x;
    assign o_cipher_y = r_out_y;

endmodule

@@ rtl/core/spk_ctrl.sv @@
module spk_ctrl
    import spk_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = 27
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ROUND_COUNT);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             out_free;
    logic             rounds_done;

    assign out_free    = !r_out_valid || i_out_ready;
    assign rounds_done = (r_cnt == LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_RUN;
            ST_RUN:  if (rounds_done && out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load      = 1'b0;
        o_cmd.step      = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.round_idx = r_cnt;
        o_in_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_RUN: begin
                o_cmd.step = !rounds_done;
                o_cmd.emit = rounds_done && out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_cnt <= '0;
            end else if (o_cmd.step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_emit_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == ST_RUN && r_cnt == LAST))
        else $error("result emitted before last round");

    a_load_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_RUN && r_cnt == '0))
        else $error("load did not start round zero");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST)
        else $error("round counter past last round");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.emit))
        else $error("output valid without emit");

endmodule

@@ rtl/core/speck64_128_block_encrypt.sv @@
// Channel  Direction  Handshake                      Payload
// s_axis   in         s_axis_tvalid / s_axis_tready  plain_x, plain_y
// m_axis   out        m_axis_tvalid / m_axis_tready  cipher_x, cipher_y
// cfg      in         i_cfg_valid / o_cfg_ready      key word index, key word
//
// A block goes through the accept cycle that loads the words and key, one round
// per cycle through a single round/key-schedule unit, and the cycle that moves
// the result into the output register.
// A new block is taken once the previous one has reached the output register.
// If the output register is still full at the last round, the block waits.
// Reset clears the key words and control; the cfg channel is always ready.
module speck64_128_block_encrypt
    import spk_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = 27
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // plain_x[31:0], plain_y[63:32]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // cipher_x[31:0], cipher_y[63:32]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_dp_cmd cmd;
    t_word   cipher_x, cipher_y;

    assign o_cfg_ready = 1'b1;

    spk_ctrl #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    spk_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_plain_x   (s_axis_tdata[31:0]),
        .i_plain_y   (s_axis_tdata[63:32]),
        .o_cipher_x  (cipher_x),
        .o_cipher_y  (cipher_y)
    );

    assign m_axis_tdata = {cipher_y, cipher_x};

endmodule
